>>> hw/rtl/adsr_pkg.sv
package adsr_pkg;

  localparam int LevelFracBits = 23;
  localparam int LevelW        = 24;
  localparam int CfgW          = 24;
  localparam int CfgIdxW       = 2;
  localparam int PhaseW        = 3;

  localparam logic [LevelW-1:0] LevelOne = LevelW'(1) << LevelFracBits;

  // Phase codes
  localparam logic [PhaseW-1:0] PH_IDLE    = 3'd0;
  localparam logic [PhaseW-1:0] PH_ATTACK  = 3'd1;
  localparam logic [PhaseW-1:0] PH_DECAY   = 3'd2;
  localparam logic [PhaseW-1:0] PH_SUSTAIN = 3'd3;
  localparam logic [PhaseW-1:0] PH_RELEASE = 3'd4;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_ATTACK_STEP   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DECAY_STEP    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SUSTAIN_LEVEL = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_STEP  = 2'd3;

  localparam logic [CfgW-1:0] AttackStepRst   = 24'd175;
  localparam logic [CfgW-1:0] DecayStepRst    = 24'd175;
  localparam logic [CfgW-1:0] SustainLevelRst = 24'd4194304;
  localparam logic [CfgW-1:0] ReleaseStepRst  = 24'd87;

  typedef struct packed {
    logic [CfgW-1:0] attack_step;
    logic [CfgW-1:0] decay_step;
    logic [CfgW-1:0] sustain_level;
    logic [CfgW-1:0] release_step;
  } adsr_cfg_t;

endpackage

>>> hw/rtl/adsr_in_if.sv
interface adsr_in_if;
  logic valid;
  logic ready;
  logic gate;

  modport source (output valid, output gate, input ready);
  modport sink   (input valid, input gate, output ready);
endinterface

>>> hw/rtl/adsr_out_if.sv
interface adsr_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] level;
  logic [2:0]  phase;

  modport source (output valid, output level, output phase, input ready);
  modport sink   (input valid, input level, input phase, output ready);
endinterface

>>> hw/rtl/adsr_cfg.sv
module adsr_cfg
  import adsr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output adsr_cfg_t          cfg_o
);

  adsr_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_step   <= AttackStepRst;
      cfg_q.decay_step    <= DecayStepRst;
      cfg_q.sustain_level <= SustainLevelRst;
      cfg_q.release_step  <= ReleaseStepRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ATTACK_STEP:   cfg_q.attack_step   <= cfg_wdata_i;
        CFG_DECAY_STEP:    cfg_q.decay_step    <= cfg_wdata_i;
        CFG_SUSTAIN_LEVEL: cfg_q.sustain_level <= cfg_wdata_i;
        CFG_RELEASE_STEP:  cfg_q.release_step  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/adsr_step.sv
module adsr_step
  import adsr_pkg::*;
(
  input  adsr_cfg_t         cfg_i,
  input  logic              gate_i,
  input  logic [PhaseW-1:0] phase_i,
  input  logic [LevelW-1:0] level_i,
  output logic [PhaseW-1:0] phase_o,
  output logic [LevelW-1:0] level_o
);

  logic [PhaseW-1:0] phase_gated;
  logic [LevelW-1:0] sus;
  logic [LevelW-1:0] atk_step;
  logic [LevelW:0]   atk_sum;
  logic [LevelW:0]   dec_floor;

  // Saturate sustain to full scale
  assign sus      = (cfg_i.sustain_level > LevelOne) ? LevelOne : cfg_i.sustain_level;
  assign atk_step = (cfg_i.attack_step == '0) ? LevelW'(1) : cfg_i.attack_step;
  assign atk_sum  = {1'b0, level_i} + {1'b0, atk_step};
  assign dec_floor = {1'b0, sus} + {1'b0, cfg_i.decay_step};

  always_comb begin
    if (gate_i && phase_i == PH_IDLE) begin
      phase_gated = PH_ATTACK;
    end else if (!gate_i && phase_i != PH_IDLE && phase_i != PH_RELEASE) begin
      phase_gated = PH_RELEASE;
    end else begin
      phase_gated = phase_i;
    end
  end

  always_comb begin
    phase_o = phase_gated;
    level_o = level_i;
    unique case (phase_gated)
      PH_ATTACK: begin
        if (atk_sum >= {1'b0, LevelOne}) begin
          level_o = LevelOne;
          phase_o = PH_DECAY;
        end else begin
          level_o = atk_sum[LevelW-1:0];
        end
      end
      PH_DECAY: begin
        if ({1'b0, level_i} <= dec_floor) begin
          level_o = sus;
          phase_o = PH_SUSTAIN;
        end else begin
          level_o = level_i - cfg_i.decay_step;
        end
      end
      PH_SUSTAIN: begin
        level_o = sus;
      end
      PH_RELEASE: begin
        // a zero release step drops to idle at once
        if (cfg_i.release_step == '0 || level_i <= cfg_i.release_step) begin
          level_o = '0;
          phase_o = PH_IDLE;
        end else begin
          level_o = level_i - cfg_i.release_step;
        end
      end
      default: begin
        level_o = '0;
        phase_o = PH_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/adsr_envelope_generator_top.sv
// Channel  Dir  Payload                    Beat
// -------  ---  -------------------------  ------------------------------------
// in_i     in   gate (1b)                  one audio sample tick
// out_o    out  level (24b Q1.23), phase   envelope after that sample
// cfg      in   cfg_we_i/idx (2b)/wdata    one register write, no read-back
//
// One beat in, one beat out; sustained rate is one sample per cycle while
// out_o is not stalled. The path runs through a gate register, then the
// phase/level state, which doubles as the output register. Reset (rst_ni,
// async, low) clears both stages, sets idle at level zero and loads the
// default steps. A stall on out_o holds the state; in_i still takes one more
// beat into the gate register, then drops ready until out_o drains.
module adsr_envelope_generator_top
  import adsr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  adsr_in_if.sink            in_i,
  adsr_out_if.source         out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  adsr_cfg_t         cfg;
  logic              gate_vld_q;
  logic              gate_q;
  logic              out_vld_q;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [LevelW-1:0] level_q, level_d;
  logic              advance;
  logic              in_fire;

  adsr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Step the envelope when a gate is held and the output slot is free
  assign advance  = gate_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !gate_vld_q || advance;
  assign in_fire  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      gate_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      gate_q <= in_i.gate;
    end
  end

  adsr_step u_step (
    .cfg_i   (cfg),
    .gate_i  (gate_q),
    .phase_i (phase_q),
    .level_i (level_q),
    .phase_o (phase_d),
    .level_o (level_d)
  );

  // Envelope state; also the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      level_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        phase_q <= phase_d;
        level_q <= level_d;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.level = level_q;
  assign out_o.phase = phase_q;

  a_level_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> level_q <= LevelOne)
    else $error("level above full scale");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && phase_q == PH_IDLE) |-> level_q == '0)
    else $error("idle with nonzero level");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (gate_vld_q && out_vld_q && !out_o.ready))
    else $error("input stalled without backpressure");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(level_q) && $stable(phase_q)))
    else $error("state moved without a step");

endmodule

>>> tb/tb_adsr_envelope_generator_top.sv
module tb_adsr_envelope_generator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import adsr_pkg::*;

  // Any stretch this long with no beat and no register write is a hang.
  localparam int WatchdogLimit = 2000;
  // Pipeline is two deep; leave a little extra before touching the registers.
  localparam int SettleCycles  = 4;
  localparam int NumSegments   = 8;
  localparam int SegItems      = 106;
  localparam int MaxReports    = 10;

  localparam logic [CfgW-1:0] CfgAllOnes = '1;
  localparam logic [CfgW-1:0] GateLo     = CfgW'(0);
  localparam logic [CfgW-1:0] GateHi     = CfgW'(1);

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [PhaseW-1:0] phase;
  } env_beat_t;

  // Directed rows: register writes, gate beats checked against the predictor,
  // and gate beats whose result is typed in right here.
  typedef enum logic [1:0] {ROW_WRITE, ROW_GATE, ROW_GATE_CHK} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [CfgIdxW-1:0] idx;
    logic [CfgW-1:0]    value;
    logic [LevelW-1:0]  exp_level;
    logic [PhaseW-1:0]  exp_phase;
  } stim_row_t;

  stim_row_t dir_tab [43] = '{
    // Out of reset: default steps, 175 up and 87 down
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateLo, 24'd0, PH_IDLE},
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateHi, 24'd175, PH_ATTACK},
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateLo, 24'd88, PH_RELEASE},
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateLo, 24'd1, PH_RELEASE},
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateLo, 24'd0, PH_IDLE},
    // Full-scale attack in one sample, sustain above full scale, zero decay,
    // zero release step drops straight to idle
    '{ROW_WRITE, CFG_ATTACK_STEP, LevelOne, 24'd0, PH_IDLE},
    '{ROW_WRITE, CFG_DECAY_STEP, 24'd0, 24'd0, PH_IDLE},
    '{ROW_WRITE, CFG_SUSTAIN_LEVEL, CfgAllOnes, 24'd0, PH_IDLE},
    '{ROW_WRITE, CFG_RELEASE_STEP, 24'd0, 24'd0, PH_IDLE},
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateHi, LevelOne, PH_DECAY},
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateHi, LevelOne, PH_SUSTAIN},
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateHi, LevelOne, PH_SUSTAIN},
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateLo, 24'd0, PH_IDLE},
    // Zero attack step counts as one; widest decay; release of full scale
    '{ROW_WRITE, CFG_ATTACK_STEP, 24'd0, 24'd0, PH_IDLE},
    '{ROW_WRITE, CFG_DECAY_STEP, CfgAllOnes, 24'd0, PH_IDLE},
    '{ROW_WRITE, CFG_SUSTAIN_LEVEL, 24'd0, 24'd0, PH_IDLE},
    '{ROW_WRITE, CFG_RELEASE_STEP, LevelOne, 24'd0, PH_IDLE},
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateHi, 24'd1, PH_ATTACK},
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateHi, 24'd2, PH_ATTACK},
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateLo, 24'd0, PH_IDLE},
    // Zero decay step parks the level above sustain; raising sustain
    // mid-decay lands on it at once; gate high again in release is ignored
    '{ROW_WRITE, CFG_ATTACK_STEP, LevelOne, 24'd0, PH_IDLE},
    '{ROW_WRITE, CFG_DECAY_STEP, 24'd0, 24'd0, PH_IDLE},
    '{ROW_WRITE, CFG_SUSTAIN_LEVEL, 24'd4194304, 24'd0, PH_IDLE},
    '{ROW_WRITE, CFG_RELEASE_STEP, 24'd1, 24'd0, PH_IDLE},
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateHi, LevelOne, PH_DECAY},
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateHi, LevelOne, PH_DECAY},
    '{ROW_WRITE, CFG_SUSTAIN_LEVEL, LevelOne, 24'd0, PH_IDLE},
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateHi, LevelOne, PH_SUSTAIN},
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateLo, 24'd8388607, PH_RELEASE},
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateHi, 24'd8388606, PH_RELEASE},
    '{ROW_WRITE, CFG_RELEASE_STEP, CfgAllOnes, 24'd0, PH_IDLE},
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateLo, 24'd0, PH_IDLE},
    // Steps that overshoot full scale, the sustain level and zero
    '{ROW_WRITE, CFG_ATTACK_STEP, 24'd5000000, 24'd0, PH_IDLE},
    '{ROW_WRITE, CFG_DECAY_STEP, 24'd3000000, 24'd0, PH_IDLE},
    '{ROW_WRITE, CFG_SUSTAIN_LEVEL, 24'd1000000, 24'd0, PH_IDLE},
    '{ROW_WRITE, CFG_RELEASE_STEP, 24'd600000, 24'd0, PH_IDLE},
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateHi, 24'd5000000, PH_ATTACK},
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateHi, LevelOne, PH_DECAY},
    '{ROW_GATE, CFG_ATTACK_STEP, GateHi, 24'd0, PH_IDLE},
    '{ROW_GATE, CFG_ATTACK_STEP, GateHi, 24'd0, PH_IDLE},
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateHi, 24'd1000000, PH_SUSTAIN},
    '{ROW_GATE, CFG_ATTACK_STEP, GateLo, 24'd0, PH_IDLE},
    '{ROW_GATE_CHK, CFG_ATTACK_STEP, GateLo, 24'd0, PH_IDLE}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_wdata_i;

  adsr_in_if  in_if ();
  adsr_out_if out_if ();

  adsr_envelope_generator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Shadow copy of the register file and the envelope state.
  logic [CfgW-1:0]   cfg_attack  = AttackStepRst;
  logic [CfgW-1:0]   cfg_decay   = DecayStepRst;
  logic [CfgW-1:0]   cfg_sustain = SustainLevelRst;
  logic [CfgW-1:0]   cfg_release = ReleaseStepRst;
  logic [PhaseW-1:0] env_ph      = PH_IDLE;
  int unsigned       env_lvl     = 0;

  env_beat_t expected_env_q [$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int mismatches      = 0;
  int beats_checked   = 0;
  int gates_sent      = 0;
  int regs_written    = 0;
  int phase_seen [5]  = '{default: 0};

  // Advance the envelope by one sample tick and return the beat it emits.
  function automatic env_beat_t next_envelope(input logic gate);
    int unsigned sus;
    int unsigned stp;
    env_beat_t   res;
    // Sustain above full scale saturates to full scale.
    sus = 32'(cfg_sustain > LevelOne ? LevelOne : cfg_sustain);
    if (gate && env_ph == PH_IDLE) begin
      env_ph = PH_ATTACK;
    end else if (!gate && env_ph != PH_IDLE && env_ph != PH_RELEASE) begin
      env_ph = PH_RELEASE;
    end
    case (env_ph)
      PH_ATTACK: begin
        stp = (cfg_attack == '0) ? 32'd1 : 32'(cfg_attack);
        if (env_lvl + stp >= 32'(LevelOne)) begin
          env_lvl = 32'(LevelOne);
          env_ph  = PH_DECAY;
        end else begin
          env_lvl += stp;
        end
      end
      PH_DECAY: begin
        if (env_lvl <= sus + 32'(cfg_decay)) begin
          env_lvl = sus;
          env_ph  = PH_SUSTAIN;
        end else begin
          env_lvl -= 32'(cfg_decay);
        end
      end
      PH_SUSTAIN: begin
        env_lvl = sus;
      end
      PH_RELEASE: begin
        if (cfg_release == '0 || env_lvl <= 32'(cfg_release)) begin
          env_lvl = 0;
          env_ph  = PH_IDLE;
        end else begin
          env_lvl -= 32'(cfg_release);
        end
      end
      default: begin
        env_ph  = PH_IDLE;
        env_lvl = 0;
      end
    endcase
    res.level = env_lvl[LevelW-1:0];
    res.phase = env_ph;
    return res;
  endfunction

  // Mostly steps that sweep a phase in about 2 to 128 samples, plus the extremes
  // and an occasional full-width value above full scale.
  function automatic logic [CfgW-1:0] pick_reg();
    case ($urandom_range(15))
      0:       return '0;
      1:       return LevelOne;
      2:       return CfgAllOnes;
      3:       return CfgW'($urandom);
      default: return (LevelOne >> $urandom_range(1, 7)) + CfgW'($urandom_range(0, 4095));
    endcase
  endfunction

  // Hold the write enable high; the next gate beat drops it.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_ATTACK_STEP:   cfg_attack  = val;
      CFG_DECAY_STEP:    cfg_decay   = val;
      CFG_SUSTAIN_LEVEL: cfg_sustain = val;
      CFG_RELEASE_STEP:  cfg_release = val;
      default: ;
    endcase
    regs_written++;
  endtask

  // Idle the sender at random, then offer one gate beat and wait for it to be
  // taken. The expected envelope beat is queued at the accepting edge.
  task automatic send_gate(input logic gate, input bit typed, input env_beat_t typed_beat);
    env_beat_t pred;
    cfg_we_i <= 1'b0;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.gate  <= gate;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    pred = next_envelope(gate);
    expected_env_q.push_back(typed ? typed_beat : pred);
    gates_sent++;
  endtask

  // Stop sending and let every outstanding beat drain, then let the pipe settle.
  task automatic drain_envelope();
    in_if.valid <= 1'b0;
    cfg_we_i    <= 1'b0;
    while (expected_env_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: stall at the rate the current phase asks for.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare every output beat, field by field, with the oldest expectation.
  always @(posedge clk_i) begin
    env_beat_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (out_if.phase <= PH_RELEASE) begin
        phase_seen[out_if.phase]++;
      end
      if (expected_env_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("[%0t] unexpected beat: level %0d phase %0d",
                   $realtime, out_if.level, out_if.phase);
        end
      end else begin
        want = expected_env_q.pop_front();
        beats_checked++;
        if (out_if.level !== want.level) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("[%0t] beat %0d level: expected %0d, got %0d",
                     $realtime, beats_checked, want.level, out_if.level);
          end
        end
        if (out_if.phase !== want.phase) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("[%0t] beat %0d phase: expected %0d, got %0d",
                     $realtime, beats_checked, want.phase, out_if.phase);
          end
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i ||
          (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[%0t] watchdog: no beat for %0d cycles, %0d beats still expected",
             $realtime, WatchdogLimit, expected_env_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    env_beat_t typed_beat;
    int        seg_sent;
    int        hold;
    int        rel;
    int        burst;

    rst_ni      <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.gate  <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_ATTACK_STEP;
    cfg_wdata_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, back to back with no idling on either side. Registers
    // change only once the envelope beats in flight have all come back.
    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_WRITE) begin
        if (r == 0 || dir_tab[r-1].kind != ROW_WRITE) begin
          drain_envelope();
        end
        write_reg(dir_tab[r].idx, dir_tab[r].value);
      end else begin
        typed_beat.level = dir_tab[r].exp_level;
        typed_beat.phase = dir_tab[r].exp_phase;
        send_gate(dir_tab[r].value[0], dir_tab[r].kind == ROW_GATE_CHK, typed_beat);
      end
    end

    // Random part in segments. Each segment starts from a drained pipe (the
    // sender waits for every expected beat), reprograms all four registers
    // and picks an idling mode: none, sender only, receiver only, both.
    for (int seg = 0; seg < NumSegments; seg++) begin
      drain_envelope();
      case (seg % 4)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 53;
          recv_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 53;
        end
        default: begin
          sender_idle_pct = 17;
          recv_stall_pct  = 17;
        end
      endcase
      case (seg)
        1: begin
          // Every register at full width
          write_reg(CFG_ATTACK_STEP, CfgAllOnes);
          write_reg(CFG_DECAY_STEP, CfgAllOnes);
          write_reg(CFG_SUSTAIN_LEVEL, CfgAllOnes);
          write_reg(CFG_RELEASE_STEP, CfgAllOnes);
        end
        2: begin
          // Instant attack, stuck decay at zero sustain, instant release
          write_reg(CFG_ATTACK_STEP, LevelOne);
          write_reg(CFG_DECAY_STEP, '0);
          write_reg(CFG_SUSTAIN_LEVEL, '0);
          write_reg(CFG_RELEASE_STEP, '0);
        end
        default: begin
          write_reg(CFG_ATTACK_STEP, pick_reg());
          write_reg(CFG_DECAY_STEP, pick_reg());
          write_reg(CFG_SUSTAIN_LEVEL, pick_reg());
          write_reg(CFG_RELEASE_STEP, pick_reg());
        end
      endcase

      seg_sent = 0;
      while (seg_sent < SegItems) begin
        if ($urandom_range(99) < 85) begin
          // Hold the gate, then release it; the release may end before the level decays away.
          hold = $urandom_range(1, 60);
          rel  = $urandom_range(1, 40);
          for (int k = 0; k < hold + rel; k++) begin
            send_gate(k < hold, 1'b0, '0);
          end
          seg_sent += hold + rel;
        end else begin
          // Gate chatter: retriggers and releases in the middle of phases.
          burst = $urandom_range(1, 8);
          for (int k = 0; k < burst; k++) begin
            send_gate($urandom_range(1), 1'b0, '0);
          end
          seg_sent += burst;
        end
      end
    end

    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    drain_envelope();

    $display("Sent %0d gate beats and %0d register writes; %0d envelope beats checked.",
             gates_sent, regs_written, beats_checked);
    $display("Beats per phase: idle %0d attack %0d decay %0d sustain %0d release %0d",
             phase_seen[0], phase_seen[1], phase_seen[2], phase_seen[3], phase_seen[4]);
    if (mismatches == 0 && expected_env_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
